/* hdl/psg_three_tone_sound_generator_unit_macros.svh */
// ----------------------------------------------------------------------------
// PSG assertion macros
// Shared concurrent assertion forms, clocked by clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PSG_THREE_TONE_SOUND_GENERATOR_UNIT_MACROS_SVH
`define PSG_THREE_TONE_SOUND_GENERATOR_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define PSG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PSG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/psg_pkg.sv */
// ----------------------------------------------------------------------------
// PSG package
// Register map, envelope codes, queue sizing and the volume tables.
// ----------------------------------------------------------------------------
package psg_pkg;

	localparam int NUM_REGS = 14;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [3:0] REG_TONE_A_LO = 4'd0;
	localparam logic [3:0] REG_TONE_A_HI = 4'd1;
	localparam logic [3:0] REG_TONE_B_LO = 4'd2;
	localparam logic [3:0] REG_TONE_B_HI = 4'd3;
	localparam logic [3:0] REG_TONE_C_LO = 4'd4;
	localparam logic [3:0] REG_TONE_C_HI = 4'd5;
	localparam logic [3:0] REG_NOISE = 4'd6;
	localparam logic [3:0] REG_MUTE = 4'd7;
	localparam logic [3:0] REG_VOL_A = 4'd8;
	localparam logic [3:0] REG_VOL_B = 4'd9;
	localparam logic [3:0] REG_VOL_C = 4'd10;
	localparam logic [3:0] REG_ENV_LO = 4'd11;
	localparam logic [3:0] REG_ENV_HI = 4'd12;
	localparam logic [3:0] REG_SHAPE = 4'd13;

	localparam logic CFG_CPS = 1'b0;
	localparam logic CFG_YM = 1'b1;
	localparam logic [15:0] CPS_RESET = 16'd40;
	localparam logic [16:0] TICK_CLOCKS = 17'd8;

	localparam logic [1:0] ENV_HOLD = 2'd0;
	localparam logic [1:0] ENV_UP = 2'd1;
	localparam logic [1:0] ENV_DOWN = 2'd2;
	localparam int SHAPE_ATTACK_BIT = 2;

	localparam logic [3:0] SHAPE_SAW_DOWN = 4'd8;
	localparam logic [3:0] SHAPE_TRI_DOWN = 4'd10;
	localparam logic [3:0] SHAPE_DOWN_HOLD_HI = 4'd11;
	localparam logic [3:0] SHAPE_SAW_UP = 4'd12;
	localparam logic [3:0] SHAPE_UP_HOLD_HI = 4'd13;
	localparam logic [3:0] SHAPE_TRI_UP = 4'd14;

	typedef struct packed {
		logic is_tick;
		logic [3:0] addr;
		logic [7:0] data;
		logic env_restart;
	} psg_cmd_t;

	localparam logic [15:0] AY_TABLE [32] = '{
		16'h0000, 16'h0000, 16'h0340, 16'h0340, 16'h04C0, 16'h04C0, 16'h06F2, 16'h06F2,
		16'h0A44, 16'h0A44, 16'h0F13, 16'h0F13, 16'h1510, 16'h1510, 16'h227E, 16'h227E,
		16'h289F, 16'h289F, 16'h414E, 16'h414E, 16'h5B21, 16'h5B21, 16'h7258, 16'h7258,
		16'h905E, 16'h905E, 16'hB550, 16'hB550, 16'hD7A0, 16'hD7A0, 16'hFFFF, 16'hFFFF};

	localparam logic [15:0] YM_TABLE [32] = '{
		16'h0000, 16'h0000, 16'h00EF, 16'h01D0, 16'h0290, 16'h032A, 16'h03EE, 16'h04D2,
		16'h0611, 16'h0782, 16'h0912, 16'h0A36, 16'h0C31, 16'h0EB6, 16'h1130, 16'h13A0,
		16'h1751, 16'h1BF5, 16'h20E2, 16'h2594, 16'h2CA1, 16'h357F, 16'h3E45, 16'h475E,
		16'h5502, 16'h6620, 16'h7730, 16'h8844, 16'hA1D2, 16'hC102, 16'hE0A2, 16'hFFFF};

	function automatic logic [15:0] vol_level(input logic ym, input logic [4:0] idx);
		return ym ? YM_TABLE[idx] : AY_TABLE[idx];
	endfunction

endpackage

/* hdl/psg_ifs.sv */
// ----------------------------------------------------------------------------
// PSG channel interfaces
// Request channel (register writes and ticks) and sample channel.
// ----------------------------------------------------------------------------
interface psg_req_if;
	logic valid;
	logic ready;
	logic mode;
	logic [3:0] reg_addr;
	logic [7:0] reg_data;

	modport source (output valid, mode, reg_addr, reg_data, input ready);
	modport sink (input valid, mode, reg_addr, reg_data, output ready);
endinterface

interface psg_smp_if;
	logic valid;
	logic ready;
	logic [15:0] level_a;
	logic [15:0] level_b;
	logic [15:0] level_c;

	modport source (output valid, level_a, level_b, level_c, input ready);
	modport sink (input valid, level_a, level_b, level_c, output ready);
endinterface

/* hdl/psg_three_tone_sound_generator_unit.sv */
// ----------------------------------------------------------------------------
// PSG three tone sound generator unit
// Top level: APB configuration registers, front end, command queue, back end.
// ----------------------------------------------------------------------------
// Each request is a sound register write or a timer tick. The front end
// accepts one request per cycle into a two-entry queue while it is not full;
// the back end retires one per cycle unless stalled, so the sustained rate is
// one request per clock while samples are taken. A sample is registered in
// the output stage when the back end retires its tick. The back end stalls
// only while its output register holds a sample that has not been taken; the
// queue then fills and the request channel stalls after at most two more requests.
module psg_three_tone_sound_generator_unit (
	input logic clk,
	input logic arst_n,
	psg_req_if.sink req,
	psg_smp_if.source smp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import psg_pkg::*;

	logic [15:0] cps_q;
	logic ym_q;
	logic push;
	logic full;
	logic pop;
	logic head_valid;
	psg_cmd_t push_cmd;
	psg_cmd_t head_cmd;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == CFG_YM) ? {31'd0, ym_q} : {16'd0, cps_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cps_q <= CPS_RESET;
			ym_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == CFG_CPS) begin
				cps_q <= pwdata[15:0];
			end else begin
				ym_q <= pwdata[0];
			end
		end
	end

	psg_front u_front (
		.req(req),
		.full(full),
		.push(push),
		.cmd(push_cmd)
	);

	psg_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(full),
		.pop(pop),
		.head_valid(head_valid),
		.head_cmd(head_cmd)
	);

	psg_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_cmd(head_cmd),
		.pop(pop),
		.cps(cps_q),
		.ym(ym_q),
		.smp(smp)
	);
endmodule

/* hdl/psg_front.sv */
// ----------------------------------------------------------------------------
// PSG front end
// Accepts requests, masks register data, drops writes to unused addresses.
// ----------------------------------------------------------------------------
module psg_front (
	psg_req_if.sink req,
	input logic full,
	output logic push,
	output psg_pkg::psg_cmd_t cmd
);
	import psg_pkg::*;

	logic [7:0] data_m;

	always_comb begin
		case (req.reg_addr) inside
			REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI, REG_SHAPE: begin
				data_m = req.reg_data & 8'h0f;
			end
			REG_NOISE, REG_VOL_A, REG_VOL_B, REG_VOL_C: begin
				data_m = req.reg_data & 8'h1f;
			end
			default: begin
				data_m = req.reg_data;
			end
		endcase
	end

	assign req.ready = !full;
	assign cmd.is_tick = req.mode;
	assign cmd.addr = req.reg_addr;
	assign cmd.data = data_m;
	assign cmd.env_restart = !req.mode && (req.reg_addr == REG_SHAPE);
	assign push = req.valid && !full && (req.mode || (req.reg_addr < 4'(NUM_REGS)));
endmodule

/* hdl/psg_queue.sv */
// ----------------------------------------------------------------------------
// PSG command queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "psg_three_tone_sound_generator_unit_macros.svh"

module psg_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input psg_pkg::psg_cmd_t push_cmd,
	output logic full,
	input logic pop,
	output logic head_valid,
	output psg_pkg::psg_cmd_t head_cmd
);
	import psg_pkg::*;

	psg_cmd_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PSG_ASSERT_NOW(a_pop_nonempty, pop, count_q != '0, "Pop from an empty queue.")
	`PSG_ASSERT_NEXT(a_push_grows, push && !pop, count_q == $past(count_q) + 1'b1,
		"Queue count did not grow on a push.")
endmodule

/* hdl/psg_back.sv */
// ----------------------------------------------------------------------------
// PSG back end
// Sound registers, tone/noise/envelope timers, sample timing and output stage.
// ----------------------------------------------------------------------------
`include "psg_three_tone_sound_generator_unit_macros.svh"

module psg_back (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input psg_pkg::psg_cmd_t head_cmd,
	output logic pop,
	input logic [15:0] cps,
	input logic ym,
	psg_smp_if.source smp
);
	import psg_pkg::*;

	logic [7:0] regs_q [NUM_REGS];
	logic [15:0] tone_cnt_q [3];
	logic [2:0] tone_out_q;
	logic [15:0] noise_cnt_q;
	logic [16:0] noise_sh_q;
	logic noise_out_q;
	logic [15:0] env_cnt_q;
	logic [4:0] env_lvl_q;
	logic [1:0] env_dir_q;
	logic [15:0] acc_q;
	logic out_valid_q;
	logic [15:0] level_a_q;
	logic [15:0] level_b_q;
	logic [15:0] level_c_q;

	logic [16:0] acc_sum;
	logic [16:0] acc_rem;
	logic emit;
	logic tick;
	logic [4:0] idx [3];
	logic [15:0] tone_cnt_nx [3];
	logic [2:0] tone_hit;
	logic [15:0] noise_cnt_nx;
	logic noise_hit;
	logic [16:0] noise_sh_nx;
	logic [15:0] env_cnt_nx;
	logic env_hit;
	logic [4:0] env_lvl_nx;
	logic [1:0] env_dir_nx;
	logic env_over;
	logic env_under;

	assign pop = head_valid && (!out_valid_q || smp.ready);
	assign tick = pop && head_cmd.is_tick;

	assign acc_sum = {1'b0, acc_q} + TICK_CLOCKS;
	assign emit = (acc_sum >= {1'b0, cps});
	assign acc_rem = acc_sum - {1'b0, cps};

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			if ((regs_q[REG_MUTE][ch] || tone_out_q[ch])
					&& (regs_q[REG_MUTE][ch + 3] || noise_out_q)) begin
				idx[ch] = regs_q[REG_VOL_A + ch][4] ? env_lvl_q
					: {regs_q[REG_VOL_A + ch][3:0], 1'b1};
			end else begin
				idx[ch] = '0;
			end
			tone_cnt_nx[ch] = tone_cnt_q[ch] + 16'd1;
			tone_hit[ch] = (tone_cnt_nx[ch] >= {4'd0, regs_q[2 * ch + 1][3:0],
				regs_q[2 * ch]});
		end
	end

	assign noise_cnt_nx = noise_cnt_q + 16'd1;
	assign noise_hit = (noise_cnt_nx >= {10'd0, regs_q[REG_NOISE][4:0], 1'b0});
	assign noise_sh_nx = {noise_sh_q[15:0], 1'b1} ^ {16'd0, noise_sh_q[16] ^ noise_sh_q[13]};

	assign env_cnt_nx = env_cnt_q + 16'd1;
	assign env_hit = (env_cnt_nx >= {regs_q[REG_ENV_HI], regs_q[REG_ENV_LO]});
	assign env_over = (env_dir_q == ENV_UP) && (env_lvl_q == 5'd31);
	assign env_under = (env_dir_q == ENV_DOWN) && (env_lvl_q == 5'd0);

	always_comb begin
		env_lvl_nx = env_lvl_q;
		env_dir_nx = env_dir_q;
		if (!env_over && !env_under) begin
			if (env_dir_q == ENV_UP) begin
				env_lvl_nx = env_lvl_q + 5'd1;
			end else if (env_dir_q == ENV_DOWN) begin
				env_lvl_nx = env_lvl_q - 5'd1;
			end
		end else begin
			case (regs_q[REG_SHAPE][3:0]) inside
				SHAPE_SAW_DOWN, SHAPE_SAW_UP: begin
					env_lvl_nx = env_under ? 5'd31 : 5'd0;
				end
				SHAPE_TRI_DOWN, SHAPE_TRI_UP: begin
					env_lvl_nx = env_under ? 5'd0 : 5'd31;
					env_dir_nx = env_under ? ENV_UP : ENV_DOWN;
				end
				SHAPE_DOWN_HOLD_HI, SHAPE_UP_HOLD_HI: begin
					env_lvl_nx = 5'd31;
					env_dir_nx = ENV_HOLD;
				end
				default: begin
					env_lvl_nx = 5'd0;
					env_dir_nx = ENV_HOLD;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= (4'(i) == REG_MUTE) ? 8'hff : 8'h00;
			end
			for (int ch = 0; ch < 3; ch++) begin
				tone_cnt_q[ch] <= '0;
			end
			tone_out_q <= '0;
			noise_cnt_q <= '0;
			noise_sh_q <= '0;
			noise_out_q <= 1'b0;
			env_cnt_q <= '0;
			env_lvl_q <= '0;
			env_dir_q <= ENV_HOLD;
			acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (tick && emit) begin
				out_valid_q <= 1'b1;
			end else if (smp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop && !head_cmd.is_tick) begin
				regs_q[head_cmd.addr] <= head_cmd.data;
				if (head_cmd.env_restart) begin
					env_cnt_q <= '0;
					if (head_cmd.data[SHAPE_ATTACK_BIT]) begin
						env_lvl_q <= 5'd0;
						env_dir_q <= ENV_UP;
					end else begin
						env_lvl_q <= 5'd31;
						env_dir_q <= ENV_DOWN;
					end
				end
			end
			if (tick) begin
				if (emit) begin
					acc_q <= acc_rem[16] ? 16'hFFFF : acc_rem[15:0];
				end else begin
					acc_q <= acc_sum[15:0];
				end
				for (int ch = 0; ch < 3; ch++) begin
					tone_cnt_q[ch] <= tone_hit[ch] ? 16'd0 : tone_cnt_nx[ch];
					if (tone_hit[ch]) begin
						tone_out_q[ch] <= !tone_out_q[ch];
					end
				end
				noise_cnt_q <= noise_hit ? 16'd0 : noise_cnt_nx;
				if (noise_hit) begin
					noise_sh_q <= noise_sh_nx;
					noise_out_q <= noise_sh_nx[16];
				end
				env_cnt_q <= env_hit ? 16'd0 : env_cnt_nx;
				if (env_hit) begin
					env_lvl_q <= env_lvl_nx;
					env_dir_q <= env_dir_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick && emit) begin
			level_a_q <= vol_level(ym, idx[0]);
			level_b_q <= vol_level(ym, idx[1]);
			level_c_q <= vol_level(ym, idx[2]);
		end
	end

	assign smp.valid = out_valid_q;
	assign smp.level_a = level_a_q;
	assign smp.level_b = level_b_q;
	assign smp.level_c = level_c_q;

	`PSG_ASSERT_NEXT(a_emit_loads, tick && emit, out_valid_q,
		"A sample tick did not load the output stage.")
	`PSG_ASSERT_NEXT(a_env_restart, pop && head_cmd.env_restart, env_cnt_q == '0,
		"Shape write did not clear the envelope timer.")
endmodule
